// ===== src/mtnf_pkg.sv =====
// shared types and constants of the markup tag nesting filter
package mtnf_pkg;

	localparam int CfgIndexWidth = 3;
	localparam int CfgDataWidth  = 64;
	localparam int ElemWidth     = 7;
	localparam int DepthWidth    = 6;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_END   = 2'd1,
		OP_TEXT  = 2'd2,
		OP_EOD   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		EV_OPEN     = 3'd0,
		EV_CLOSE    = 3'd1,
		EV_EMPTY    = 3'd2,
		EV_TEXT     = 3'd3,
		EV_OVERFLOW = 3'd4
	} ev_t;

	typedef enum logic [CfgIndexWidth-1:0] {
		CFG_SEL_LO     = 3'd0,
		CFG_SEL_HI     = 3'd1,
		CFG_SUP_LO     = 3'd2,
		CFG_SUP_HI     = 3'd3,
		CFG_STRIP_LO   = 3'd4,
		CFG_STRIP_HI   = 3'd5,
		CFG_SUP_DEF    = 3'd6,
		CFG_STRIP_TEXT = 3'd7
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SRCH_RD,
		ST_SRCH_CMP,
		ST_POP_RD,
		ST_POP_DO,
		ST_FLUSH
	} st_t;

	typedef struct packed {
		logic                 suppressed;
		logic [ElemWidth-1:0] element;
	} stack_entry_t;

	typedef struct packed {
		logic         rd_en;
		logic         wr_en;
		stack_entry_t wr_data;
	} stk_ctl_t;

	typedef struct packed {
		logic sel;
		logic sup;
		logic strip;
		logic sup_default;
		logic strip_text;
	} cfg_flags_t;

	typedef struct packed {
		ev_t                   kind;
		logic [ElemWidth-1:0]  element;
		logic [DepthWidth-1:0] depth;
		logic                  last;
	} res_t;

endpackage

// ===== src/mtnf_if.sv =====
// channel interfaces: parser events, result events and configuration writes
interface mtnf_event_if import mtnf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	op_t                  opcode;
	logic [ElemWidth-1:0] element;
	logic                 is_empty_element;
	logic                 tag_known;
	logic                 is_lone_newline;

	modport source (output valid, opcode, element, is_empty_element, tag_known,
		is_lone_newline, input ready);
	modport sink (input valid, opcode, element, is_empty_element, tag_known,
		is_lone_newline, output ready);
endinterface

interface mtnf_result_if import mtnf_pkg::*; ();
	logic                  valid;
	logic                  ready;
	ev_t                   event_kind;
	logic [ElemWidth-1:0]  element_out;
	logic [DepthWidth-1:0] depth;
	logic                  last;

	modport source (output valid, event_kind, element_out, depth, last, input ready);
	modport sink (input valid, event_kind, element_out, depth, last, output ready);
endinterface

interface mtnf_cfg_if import mtnf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	cfg_idx_t                index;
	logic [CfgDataWidth-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== src/markup_tag_nesting_filter.sv =====
// top level of the markup tag nesting filter
//
//   channel   modport   carries
//   events    sink      opcode, element, is_empty_element, tag_known, is_lone_newline
//   results   source    event_kind, element_out, depth, last
//   cfg       sink      index, data (always ready)
//
// an end tag searches the stack from the top, reading and checking each entry,
// then pops down to any match; end of document pops every entry; all stack
// reads use the single read port of the stack memory; events is ready only in
// the idle state; a held result waits in the output register while the next
// request is taken, and a full result path stalls the sequencer; reset clears
// the stack count, so the memory needs no clearing
module markup_tag_nesting_filter import mtnf_pkg::*; #(
	parameter int STACK_DEPTH   = 32,
	parameter int ELEMENT_COUNT = 128
) (
	input  logic          clk,
	input  logic          arst_n,
	mtnf_event_if.sink    events,
	mtnf_result_if.source results,
	mtnf_cfg_if.sink      cfg
);

	localparam int IW = $clog2(STACK_DEPTH);

	cfg_flags_t           flags;
	logic [ElemWidth-1:0] element;
	stk_ctl_t             stk;
	logic [IW-1:0]        wr_addr;
	logic [IW-1:0]        rd_addr;
	stack_entry_t         rd_data;

	mtnf_cfg #(
		.ELEMENT_COUNT (ELEMENT_COUNT)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.element (element),
		.flags   (flags)
	);

	mtnf_stack #(
		.DEPTH (STACK_DEPTH),
		.IW    (IW)
	) u_stack (
		.clk       (clk),
		.ctl       (stk),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data)
	);

	mtnf_ctrl #(
		.STACK_DEPTH (STACK_DEPTH),
		.IW          (IW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.events  (events),
		.results (results),
		.flags   (flags),
		.element (element),
		.stk     (stk),
		.wr_addr (wr_addr),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

endmodule

// ===== src/mtnf_cfg.sv =====
// configuration registers and element set lookup
module mtnf_cfg import mtnf_pkg::*; #(
	parameter int ELEMENT_COUNT = 128
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mtnf_cfg_if.sink             cfg,
	input  logic [ElemWidth-1:0] element,
	output cfg_flags_t           flags
);

	localparam int EW = $clog2(ELEMENT_COUNT);

	logic [ELEMENT_COUNT-1:0] sel_q;
	logic [ELEMENT_COUNT-1:0] sup_q;
	logic [ELEMENT_COUNT-1:0] strip_q;
	logic                     sup_default_q;
	logic                     strip_text_q;
	logic                     in_range;
	logic [EW-1:0]            idx;
	logic                     wr;

	assign cfg.ready = 1'b1;
	assign wr = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_q         <= '0;
			sup_q         <= '0;
			strip_q       <= '0;
			sup_default_q <= 1'b0;
			strip_text_q  <= 1'b0;
		end else if (wr) begin
			for (int b = 0; b < ELEMENT_COUNT; b++) begin
				if (b < 64) begin
					if (cfg.index == CFG_SEL_LO)   sel_q[b]   <= cfg.data[6'(b)];
					if (cfg.index == CFG_SUP_LO)   sup_q[b]   <= cfg.data[6'(b)];
					if (cfg.index == CFG_STRIP_LO) strip_q[b] <= cfg.data[6'(b)];
				end else begin
					if (cfg.index == CFG_SEL_HI)   sel_q[b]   <= cfg.data[6'(b)];
					if (cfg.index == CFG_SUP_HI)   sup_q[b]   <= cfg.data[6'(b)];
					if (cfg.index == CFG_STRIP_HI) strip_q[b] <= cfg.data[6'(b)];
				end
			end
			if (cfg.index == CFG_SUP_DEF)    sup_default_q <= cfg.data[0];
			if (cfg.index == CFG_STRIP_TEXT) strip_text_q  <= cfg.data[0];
		end
	end

	assign in_range = {1'b0, element} < 8'(ELEMENT_COUNT);
	assign idx      = element[EW-1:0];

	always_comb begin
		flags.sel         = in_range && sel_q[idx];
		flags.sup         = in_range && sup_q[idx];
		flags.strip       = in_range && strip_q[idx];
		flags.sup_default = sup_default_q;
		flags.strip_text  = strip_text_q;
	end

endmodule

// ===== src/mtnf_stack.sv =====
// nesting stack memory, one write and one registered read port
module mtnf_stack import mtnf_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int IW    = 5
) (
	input  logic          clk,
	input  stk_ctl_t      ctl,
	input  logic [IW-1:0] wr_addr,
	input  logic [IW-1:0] rd_addr,
	output stack_entry_t  rd_data_q
);

	stack_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= ctl.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

// ===== src/mtnf_ctrl.sv =====
// sequencer: decides each request, searches and pops the stack, buffers results
module mtnf_ctrl import mtnf_pkg::*; #(
	parameter int STACK_DEPTH = 32,
	parameter int IW          = 5
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mtnf_event_if.sink           events,
	mtnf_result_if.source        results,
	input  cfg_flags_t           flags,
	output logic [ElemWidth-1:0] element,
	output stk_ctl_t             stk,
	output logic [IW-1:0]        wr_addr,
	output logic [IW-1:0]        rd_addr,
	input  stack_entry_t         rd_data
);

	localparam int CW = $clog2(STACK_DEPTH + 1);

	st_t                  state_q, state_d;
	op_t                  op_q;
	logic [ElemWidth-1:0] elem_q;
	logic                 empty_q, known_q, lone_q;
	logic [CW-1:0]        count_q;
	logic [IW-1:0]        srch_q, match_q;
	logic                 pend_valid_q, out_valid_q;
	res_t                 pend_q, out_q;

	logic          accept, out_free, full, stack_nonempty, supp_now, supp_path;
	logic [IW-1:0] top_idx;
	logic          emit_req, stall, push, load_out, flush_load, hit;
	res_t          emit_r, load_r;

	assign accept         = events.valid && events.ready;
	assign events.ready   = state_q == ST_IDLE;
	assign out_free       = !out_valid_q || results.ready;
	assign full           = count_q == CW'(STACK_DEPTH);
	assign stack_nonempty = count_q != '0;
	assign top_idx        = IW'(count_q - 1'b1);
	assign supp_now       = stack_nonempty ? rd_data.suppressed : flags.sup_default;
	assign supp_path      = (supp_now && !flags.sel) || (!supp_now && flags.sup);
	assign hit            = rd_data.element == elem_q;
	assign element        = elem_q;

	// result and push decisions
	always_comb begin
		emit_req = 1'b0;
		emit_r   = '{kind: EV_OPEN, element: elem_q, depth: DepthWidth'(count_q), last: 1'b0};
		push     = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				case (op_q)
					OP_START: begin
						if (!flags.strip) begin
							if (supp_path) begin
								if (!empty_q) begin
									if (full) begin
										emit_req    = 1'b1;
										emit_r.kind = EV_OVERFLOW;
									end else begin
										push = 1'b1;
									end
								end
							end else if (known_q) begin
								emit_req = 1'b1;
								if (full) begin
									emit_r.kind = EV_OVERFLOW;
								end else if (empty_q) begin
									emit_r.kind = EV_EMPTY;
								end else begin
									push         = 1'b1;
									emit_r.kind  = EV_OPEN;
									emit_r.depth = DepthWidth'(count_q + 1'b1);
								end
							end
						end
					end
					OP_TEXT: begin
						if (!(flags.strip_text || supp_now || lone_q)) begin
							emit_req       = 1'b1;
							emit_r.element = '0;
							emit_r.kind    = full ? EV_OVERFLOW : EV_TEXT;
						end
					end
					default: begin
						emit_req = 1'b0;
					end
				endcase
			end
			ST_POP_DO: begin
				emit_req       = !rd_data.suppressed;
				emit_r.kind    = EV_CLOSE;
				emit_r.element = rd_data.element;
				emit_r.depth   = DepthWidth'(count_q - 1'b1);
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	assign stall = emit_req && pend_valid_q && !out_free;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (op_q == OP_END && !flags.strip && stack_nonempty) begin
					state_d = ST_SRCH_RD;
				end else if (op_q == OP_EOD && stack_nonempty) begin
					state_d = ST_POP_RD;
				end else if (!stall) begin
					state_d = ST_FLUSH;
				end
			end
			ST_SRCH_RD: begin
				state_d = ST_SRCH_CMP;
			end
			ST_SRCH_CMP: begin
				if (hit) begin
					state_d = ST_POP_RD;
				end else if (srch_q == '0) begin
					state_d = ST_FLUSH;
				end else begin
					state_d = ST_SRCH_RD;
				end
			end
			ST_POP_RD: begin
				state_d = ST_POP_DO;
			end
			ST_POP_DO: begin
				if (!stall) begin
					state_d = (top_idx == match_q) ? ST_FLUSH : ST_POP_RD;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// stack port and output register controls
	always_comb begin
		stk.rd_en   = 1'b0;
		rd_addr     = top_idx;
		stk.wr_en   = push && !stall;
		stk.wr_data = '{suppressed: supp_path, element: elem_q};
		wr_addr     = IW'(count_q);
		flush_load  = 1'b0;
		load_out    = 1'b0;
		load_r      = pend_q;
		case (state_q)
			ST_IDLE: begin
				stk.rd_en = accept && stack_nonempty;
			end
			ST_SRCH_RD: begin
				stk.rd_en = 1'b1;
				rd_addr   = srch_q;
			end
			ST_POP_RD: begin
				stk.rd_en = 1'b1;
			end
			ST_FLUSH: begin
				flush_load  = pend_valid_q && out_free;
				load_out    = flush_load;
				load_r.last = 1'b1;
			end
			default: begin
				load_out = emit_req && pend_valid_q && out_free;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (stk.wr_en) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == ST_POP_DO && !stall) begin
				count_q <= count_q - 1'b1;
			end
			if (emit_req && !stall) begin
				pend_valid_q <= 1'b1;
			end else if (flush_load) begin
				pend_valid_q <= 1'b0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= events.opcode;
			elem_q  <= events.element;
			empty_q <= events.is_empty_element;
			known_q <= events.tag_known;
			lone_q  <= events.is_lone_newline;
		end
		if (state_q == ST_DECIDE) begin
			srch_q  <= top_idx;
			match_q <= '0;
		end else if (state_q == ST_SRCH_CMP) begin
			if (hit) begin
				match_q <= srch_q;
			end else begin
				srch_q <= srch_q - 1'b1;
			end
		end
		if (emit_req && !stall) pend_q <= emit_r;
		if (load_out) out_q <= load_r;
	end

	assign results.valid       = out_valid_q;
	assign results.event_kind  = out_q.kind;
	assign results.element_out = out_q.element;
	assign results.depth       = out_q.depth;
	assign results.last        = out_q.last;

endmodule
